FILE: hw/rtl/entity_id_allocator_with_signatures_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the entity ID allocator
// Clocked, reset-qualified property shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_TOP_ASSERT_SVH
`define ENTITY_ID_ALLOCATOR_WITH_SIGNATURES_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define EIDA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define EIDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/eida_pkg.sv
// ----------------------------------------------------------------------------
// Entity ID allocator package
// Sizes, operation and status codes, and the controller command word.
// ----------------------------------------------------------------------------
`default_nettype none

package eida_pkg;

    // Pool and signature sizes.
    localparam int ENTITY_COUNT    = 256;
    localparam int COMPONENT_COUNT = 32;
    localparam int ID_W            = 8;
    localparam int CNT_W           = 9;
    localparam int COMP_W          = 5;
    localparam int SIG_W           = COMPONENT_COUNT;

    // Operation codes; unused codes behave as a query.
    typedef enum logic [2:0] {
        OP_CREATE   = 3'd0,
        OP_DESTROY  = 3'd1,
        OP_SET_SIG  = 3'd2,
        OP_ADD_COMP = 3'd3,
        OP_REM_COMP = 3'd4,
        OP_QUERY    = 3'd5
    } opcode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_POOL_EMPTY = 2'd1,
        ST_DEAD       = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the input word and issue memory reads
        logic exec;   // update state and load the result register
    } cmd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/entity_id_allocator_with_signatures_top.sv
// ----------------------------------------------------------------------------
// Entity ID allocator with component signatures
// Hands out entity IDs from a LIFO free stack and tracks per-entity signatures.
// ----------------------------------------------------------------------------
// Each input word is handled in turn: in the cycle it is accepted the free stack
// and signature memories are read, and in the next cycle the state is updated
// and the result register is loaded. Because of this read-modify-write pass over
// these memories, no new word is accepted while one executes; a new word is
// accepted when the result register is empty or in the same cycle the previous
// result is taken. After reset the block is ready at once: the stack's initial
// contents come from a low-water mark and the alive and signature tables from
// per-entry valid bits, so there is no clearing pass.
`default_nettype none

module entity_id_allocator_with_signatures_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] target_id, [12:8] component_type, [44:13] new_signature, zero pad
    input  wire logic [47:0] s_tdata,
    // [2:0] opcode
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] result_id, [8] is_alive, [40:9] signature_out, [49:41] live_count,
    // zero pad
    output logic [55:0]      m_tdata,
    // [1:0] status
    output logic [1:0]       m_tuser
);
    import eida_pkg::*;

    cmd_t             cmd;
    logic [1:0]       status;
    logic [ID_W-1:0]  result_id;
    logic             is_alive;
    logic [31:0]      signature;
    logic [CNT_W-1:0] live_count;

    // Sequencer.
    eida_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Storage and operation logic.
    eida_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .opcode_in         (s_tuser),
        .target_id_in      (s_tdata[7:0]),
        .component_type_in (s_tdata[12:8]),
        .new_signature_in  (s_tdata[44:13]),
        .status_out        (status),
        .result_id_out     (result_id),
        .is_alive_out      (is_alive),
        .signature_out     (signature),
        .live_count_out    (live_count)
    );

    // Result word packing.
    assign m_tdata = {6'b0, live_count, signature, is_alive, result_id};
    assign m_tuser = status;

endmodule

`default_nettype wire

FILE: hw/rtl/eida_ctrl.sv
// ----------------------------------------------------------------------------
// Entity ID allocator controller
// Two-state sequencer and ownership of the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module eida_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output eida_pkg::cmd_t     cmd
);
    import eida_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // A word is taken only out of reset, in the idle state, and when the result
    // register is free or drains now.
    assign s_tready = aresetn && (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == S_EXEC);

    // Next state and result valid.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (cmd.load) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b1;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/eida_datapath.sv
// ----------------------------------------------------------------------------
// Entity ID allocator datapath
// Free stack, alive bits, signature memory, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module eida_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire eida_pkg::cmd_t                cmd,
    input  wire logic [2:0]                    opcode_in,
    input  wire logic [eida_pkg::ID_W-1:0]     target_id_in,
    input  wire logic [eida_pkg::COMP_W-1:0]   component_type_in,
    input  wire logic [31:0]                   new_signature_in,
    output logic [1:0]                         status_out,
    output logic [eida_pkg::ID_W-1:0]          result_id_out,
    output logic                               is_alive_out,
    output logic [31:0]                        signature_out,
    output logic [eida_pkg::CNT_W-1:0]         live_count_out
);
    import eida_pkg::*;

    // Captured input word.
    opcode_t             op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [COMP_W-1:0]   comp_reg;
    logic [SIG_W-1:0]    nsig_reg;

    // Memories and their registered read data. An entity entry holds its
    // alive bit above its signature.
    logic [SIG_W:0]      ent_mem [ENTITY_COUNT];
    logic [ID_W-1:0]     stk_mem [ENTITY_COUNT];
    logic [SIG_W:0]      ent_rd_reg;
    logic [ID_W-1:0]     stk_rd_reg;

    // Control state.
    logic [CNT_W-1:0]        free_top_reg, free_top_next;
    logic [CNT_W-1:0]        low_mark_reg, low_mark_next;
    logic [CNT_W-1:0]        live_reg, live_next;
    logic [ENTITY_COUNT-1:0] ent_valid_reg;

    // Result register.
    status_t             status_reg;
    logic [ID_W-1:0]     rid_reg;
    logic                alive_out_reg;
    logic [SIG_W-1:0]    sig_out_reg;

    // Execute-cycle signals.
    logic [CNT_W-1:0]    top_dec;
    logic [ID_W-1:0]     stk_raddr;
    logic [ID_W-1:0]     pop_id;
    logic [ID_W-1:0]     upd_id;
    logic                id_ok, comp_ok, alive_cur;
    logic [SIG_W:0]      cur_word;
    logic [SIG_W-1:0]    cur_sig, comp_bit;
    logic                ent_we, stk_we, alive_wdata;
    logic [SIG_W-1:0]    sig_wdata;
    status_t             st_c;
    logic [ID_W-1:0]     rid_c;
    logic                alive_c;
    logic [SIG_W-1:0]    sig_c;

    assign top_dec   = free_top_reg - CNT_W'(1);
    assign stk_raddr = top_dec[ID_W-1:0];

    // Stack slots below the lowest top ever reached have never been written and
    // are read as the slot index itself.
    assign pop_id    = (free_top_reg == low_mark_reg) ? top_dec[ID_W-1:0] : stk_rd_reg;

    // Entries never written since reset read as dead with an empty signature.
    assign cur_word  = ent_valid_reg[id_reg] ? ent_rd_reg : '0;
    assign alive_cur = cur_word[SIG_W];
    assign cur_sig   = cur_word[SIG_W-1:0];

    assign id_ok     = {1'b0, id_reg} < CNT_W'(ENTITY_COUNT);
    assign comp_ok   = {1'b0, comp_reg} < (COMP_W + 1)'(COMPONENT_COUNT);
    assign comp_bit  = SIG_W'(1) << comp_reg;
    assign upd_id    = (op_reg == OP_CREATE) ? pop_id : id_reg;

    // Capture the input word.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= opcode_t'(opcode_in);
            id_reg   <= target_id_in;
            comp_reg <= component_type_in;
            nsig_reg <= SIG_W'(new_signature_in);
        end
    end

    // Entity memory: one write and one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.exec && ent_we) begin
            ent_mem[upd_id] <= {alive_wdata, sig_wdata};
        end
        if (cmd.load) begin
            ent_rd_reg <= ent_mem[target_id_in];
        end
    end

    // Free stack memory: push at the top, read the slot under the top.
    always_ff @(posedge aclk) begin
        if (cmd.exec && stk_we) begin
            stk_mem[free_top_reg[ID_W-1:0]] <= id_reg;
        end
        if (cmd.load) begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    // Operation decode and next state.
    always_comb begin
        st_c          = ST_OK;
        rid_c         = id_reg;
        alive_c       = id_ok && alive_cur;
        sig_c         = id_ok ? cur_sig : '0;
        ent_we        = 1'b0;
        alive_wdata   = alive_cur;
        sig_wdata     = nsig_reg;
        stk_we        = 1'b0;
        free_top_next = free_top_reg;
        low_mark_next = low_mark_reg;
        live_next     = live_reg;
        case (op_reg)
            OP_CREATE: begin
                if (free_top_reg == '0) begin
                    st_c    = ST_POOL_EMPTY;
                    rid_c   = '0;
                    alive_c = 1'b0;
                    sig_c   = '0;
                end else begin
                    free_top_next = top_dec;
                    if (free_top_reg == low_mark_reg) begin
                        low_mark_next = top_dec;
                    end
                    live_next   = live_reg + CNT_W'(1);
                    ent_we      = 1'b1;
                    alive_wdata = 1'b1;
                    sig_wdata   = '0;
                    rid_c       = pop_id;
                    alive_c     = 1'b1;
                    sig_c       = '0;
                end
            end
            OP_DESTROY: begin
                if (!id_ok || !alive_cur) begin
                    st_c = ST_DEAD;
                end else begin
                    ent_we      = 1'b1;
                    alive_wdata = 1'b0;
                    sig_wdata   = '0;
                    if (free_top_reg < CNT_W'(ENTITY_COUNT)) begin
                        stk_we        = 1'b1;
                        free_top_next = free_top_reg + CNT_W'(1);
                    end
                    if (live_reg != '0) begin
                        live_next = live_reg - CNT_W'(1);
                    end
                    alive_c = 1'b0;
                    sig_c   = '0;
                end
            end
            OP_SET_SIG: begin
                if (id_ok) begin
                    ent_we = 1'b1;
                    sig_c  = nsig_reg;
                end
            end
            OP_ADD_COMP: begin
                if (id_ok && comp_ok) begin
                    ent_we    = 1'b1;
                    sig_wdata = cur_sig | comp_bit;
                    sig_c     = sig_wdata;
                end
            end
            OP_REM_COMP: begin
                if (id_ok && comp_ok) begin
                    ent_we    = 1'b1;
                    sig_wdata = cur_sig & ~comp_bit;
                    sig_c     = sig_wdata;
                end
            end
            default: begin
                // Query and the unused codes change nothing.
            end
        endcase
    end

    // Counters and entity valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_top_reg  <= CNT_W'(ENTITY_COUNT);
            low_mark_reg  <= CNT_W'(ENTITY_COUNT);
            live_reg      <= '0;
            ent_valid_reg <= '0;
        end else if (cmd.exec) begin
            free_top_reg <= free_top_next;
            low_mark_reg <= low_mark_next;
            live_reg     <= live_next;
            if (ent_we) begin
                ent_valid_reg[upd_id] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg    <= st_c;
            rid_reg       <= rid_c;
            alive_out_reg <= alive_c;
            sig_out_reg   <= sig_c;
        end
    end

    assign status_out     = status_reg;
    assign result_id_out  = rid_reg;
    assign is_alive_out   = alive_out_reg;
    assign signature_out  = 32'(sig_out_reg);
    assign live_count_out = live_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/eida_checker.sv
// ----------------------------------------------------------------------------
// Entity ID allocator port checker
// Concurrent checks on the top-level ports, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "entity_id_allocator_with_signatures_top_assert.svh"

module eida_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic [1:0]  m_tuser
);
    import eida_pkg::*;

    logic [ID_W-1:0]  res_id;
    logic             res_alive;
    logic [31:0]      res_sig;
    logic [CNT_W-1:0] res_live;
    logic             empty_res;
    logic             null_res;

    // Result word fields.
    assign res_id    = m_tdata[7:0];
    assign res_alive = m_tdata[8];
    assign res_sig   = m_tdata[40:9];
    assign res_live  = m_tdata[49:41];
    assign empty_res = m_tvalid && (m_tuser == ST_POOL_EMPTY);
    assign null_res  = (res_id == '0) && !res_alive && (res_sig == '0);

    // A stalled result word stays offered.
    `EIDA_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid, "result dropped")

    // No new word is accepted while an accepted word executes.
    `EIDA_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "input during execute")

    // An empty pool answers with a null entity.
    `EIDA_ASSERT_NOW(a_empty_null, empty_res, null_res, "pool-empty result not null")

    // The live count never exceeds the pool size.
    `EIDA_ASSERT_NOW(a_live_bound, m_tvalid, res_live <= CNT_W'(ENTITY_COUNT), "live count too high")

endmodule

bind entity_id_allocator_with_signatures_top eida_checker u_eida_checker (.*);

`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the entity ID allocator with component signatures
// Feeds opcode words into the stream input, predicts each result from a local
// copy of the free stack, alive flags and signature table, and compares every
// result word field by field while both stream sides stall at random.
// ----------------------------------------------------------------------------

module testbench;

    import eida_pkg::*;

    // Spare opcodes that the block treats as a query.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int RANDOM_WORDS = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int QUIET_FIRST  = 1200;
    localparam int QUIET_LAST   = 2200;
    localparam int DRAIN_CYCLES = 16;

    // One result word as seen on the master side.
    typedef struct packed {
        status_t        status;
        logic [ID_W-1:0]  result_id;
        logic             is_alive;
        logic [SIG_W-1:0] signature;
        logic [CNT_W-1:0] live_count;
    } alloc_result_t;

    // One directed row; the expected word is used only when typed_exp is set.
    typedef struct packed {
        logic [2:0]       op;
        logic [ID_W-1:0]  target_id;
        logic [COMP_W-1:0] comp;
        logic [SIG_W-1:0] new_sig;
        logic             typed_exp;
        alloc_result_t    exp;
    } directed_row_t;

    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } op_mix_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;

    int cycle_count    = 0;
    int mismatch_count = 0;

    // Local copy of the allocator state.
    logic [ID_W-1:0]  free_id_stack [ENTITY_COUNT];
    int               free_depth;
    logic             alive_flags   [ENTITY_COUNT];
    logic [SIG_W-1:0] signatures    [ENTITY_COUNT];
    int               living_count;

    alloc_result_t pending_alloc_results [$];

    entity_id_allocator_with_signatures_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Cycle counter with the run time limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Random idle decision shared by both sides, with a quiet window.
    function automatic bit take_break();
        if (cycle_count >= QUIET_FIRST && cycle_count < QUIET_LAST)
            return 1'b0;
        return $urandom_range(99) < 23;
    endfunction

    // Result side back-pressure.
    always @(posedge aclk) begin
        m_tready <= !take_break();
    end

    // Clear the local state to its after-reset contents.
    task automatic reset_alloc_state();
        for (int i = 0; i < ENTITY_COUNT; i++) begin
            free_id_stack[i] = ID_W'(i);
            alive_flags[i]   = 1'b0;
            signatures[i]    = '0;
        end
        free_depth   = ENTITY_COUNT;
        living_count = 0;
    endtask

    // Apply one operation to the local state and work out its result word.
    task automatic compute_alloc_result(
        input  logic [2:0]        op,
        input  logic [ID_W-1:0]   target_id,
        input  logic [COMP_W-1:0] comp,
        input  logic [SIG_W-1:0]  new_sig,
        output alloc_result_t     res
    );
        logic [ID_W-1:0] id;
        logic            id_ok;
        id    = target_id;
        id_ok = 1'b1;
        res.status = ST_OK;
        case (op)
            OP_CREATE: begin
                if (free_depth == 0) begin
                    // Nothing left to hand out.
                    res.status = ST_POOL_EMPTY;
                    id    = '0;
                    id_ok = 1'b0;
                end else begin
                    free_depth--;
                    id = free_id_stack[free_depth];
                    living_count++;
                    signatures[id]  = '0;
                    alive_flags[id] = 1'b1;
                end
            end
            OP_DESTROY: begin
                if (!alive_flags[id]) begin
                    res.status = ST_DEAD;
                end else begin
                    signatures[id]  = '0;
                    alive_flags[id] = 1'b0;
                    if (free_depth < ENTITY_COUNT) begin
                        free_id_stack[free_depth] = id;
                        free_depth++;
                    end
                    if (living_count > 0)
                        living_count--;
                end
            end
            OP_SET_SIG:  signatures[id] = new_sig;
            OP_ADD_COMP: signatures[id][comp] = 1'b1;
            OP_REM_COMP: signatures[id][comp] = 1'b0;
            default: ;
        endcase
        res.result_id  = id;
        res.is_alive   = id_ok && alive_flags[id];
        res.signature  = id_ok ? signatures[id] : '0;
        res.live_count = CNT_W'(living_count);
    endtask

    // Present one word, wait for the handshake, then record its expectation.
    task automatic send_word(
        input logic [2:0]        op,
        input logic [ID_W-1:0]   target_id,
        input logic [COMP_W-1:0] comp,
        input logic [SIG_W-1:0]  new_sig,
        input logic              typed_exp,
        input alloc_result_t     typed_res
    );
        alloc_result_t pred;
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, new_sig, comp, target_id};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        compute_alloc_result(op, target_id, comp, new_sig, pred);
        pending_alloc_results.insert(pending_alloc_results.size(),
                                     typed_exp ? typed_res : pred);
    endtask

    // Pick a living entity most of the time, otherwise any ID.
    function automatic logic [ID_W-1:0] pick_target(int live_pct);
        int start;
        start = $urandom_range(ENTITY_COUNT - 1);
        if (living_count > 0 && $urandom_range(99) < live_pct) begin
            for (int k = 0; k < ENTITY_COUNT; k++) begin
                if (alive_flags[(start + k) % ENTITY_COUNT])
                    return ID_W'((start + k) % ENTITY_COUNT);
            end
        end
        return ID_W'(start);
    endfunction

    // Opcode choice; the mix sets the share of creates and destroys.
    function automatic logic [2:0] choose_op(op_mix_t mix);
        logic [2:0] others [6];
        int r;
        int create_pct;
        int destroy_pct;
        others = '{OP_SET_SIG, OP_ADD_COMP, OP_REM_COMP, OP_QUERY, OP_SPARE_6, OP_SPARE_7};
        case (mix)
            MIX_FILL:  begin create_pct = 85; destroy_pct = 4;  end
            MIX_DRAIN: begin create_pct = 10; destroy_pct = 55; end
            default:   begin create_pct = 25; destroy_pct = 20; end
        endcase
        r = $urandom_range(99);
        if (r < create_pct)
            return OP_CREATE;
        if (r < create_pct + destroy_pct)
            return OP_DESTROY;
        return others[$urandom_range(5)];
    endfunction

    // Directed rows: extremes, every opcode, the dead-entity cases and LIFO reuse.
    directed_row_t directed_rows [25] = '{
        '{OP_QUERY,    8'd0,   5'd0,  32'h0000_0000, 1'b1,
          '{ST_OK,   8'd0,   1'b0, 32'h0, 9'd0}},
        '{OP_DESTROY,  8'd255, 5'd0,  32'h0000_0000, 1'b1,
          '{ST_DEAD, 8'd255, 1'b0, 32'h0, 9'd0}},
        '{OP_CREATE,   8'd0,   5'd0,  32'h0000_0000, 1'b1,
          '{ST_OK,   8'd255, 1'b1, 32'h0, 9'd1}},
        '{OP_CREATE,   8'd17,  5'd31, 32'hFFFF_FFFF, 1'b1,
          '{ST_OK,   8'd254, 1'b1, 32'h0, 9'd2}},
        '{OP_SET_SIG,  8'd255, 5'd0,  32'hFFFF_FFFF, 1'b0, '0},
        '{OP_REM_COMP, 8'd255, 5'd31, 32'h0000_0000, 1'b0, '0},
        '{OP_REM_COMP, 8'd255, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_ADD_COMP, 8'd254, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_ADD_COMP, 8'd254, 5'd31, 32'h0000_0000, 1'b0, '0},
        '{OP_SPARE_6,  8'd254, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_SPARE_7,  8'd255, 5'd31, 32'hFFFF_FFFF, 1'b0, '0},
        '{OP_SET_SIG,  8'd0,   5'd0,  32'hA5A5_A5A5, 1'b0, '0},
        '{OP_QUERY,    8'd0,   5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_SET_SIG,  8'd255, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_DESTROY,  8'd255, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_DESTROY,  8'd255, 5'd0,  32'h0000_0000, 1'b1,
          '{ST_DEAD, 8'd255, 1'b0, 32'h0, 9'd1}},
        '{OP_CREATE,   8'd0,   5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_ADD_COMP, 8'd1,   5'd17, 32'h0000_0000, 1'b0, '0},
        '{OP_REM_COMP, 8'd1,   5'd17, 32'h0000_0000, 1'b0, '0},
        '{OP_CREATE,   8'd0,   5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_SET_SIG,  8'd253, 5'd0,  32'h5A5A_5A5A, 1'b0, '0},
        '{OP_DESTROY,  8'd253, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_DESTROY,  8'd254, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_DESTROY,  8'd255, 5'd0,  32'h0000_0000, 1'b0, '0},
        '{OP_QUERY,    8'd255, 5'd31, 32'hFFFF_FFFF, 1'b0, '0}
    };

    // Result checker: every accepted word against the oldest expectation.
    always @(posedge aclk) begin
        alloc_result_t exp_res;
        alloc_result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = status_t'(m_tuser);
            got.result_id  = m_tdata[7:0];
            got.is_alive   = m_tdata[8];
            got.signature  = m_tdata[40:9];
            got.live_count = m_tdata[49:41];
            if (pending_alloc_results.size() == 0) begin
                $error("unexpected result word: id %0d status %0d", got.result_id, m_tuser);
                mismatch_count++;
            end else begin
                exp_res = pending_alloc_results.pop_front();
                if (got.status !== exp_res.status) begin
                    $error("status: expected %0d, got %0d", exp_res.status, m_tuser);
                    mismatch_count++;
                end
                if (got.result_id !== exp_res.result_id) begin
                    $error("result_id: expected %0d, got %0d", exp_res.result_id,
                           got.result_id);
                    mismatch_count++;
                end
                if (got.is_alive !== exp_res.is_alive) begin
                    $error("is_alive: expected %0d, got %0d", exp_res.is_alive,
                           got.is_alive);
                    mismatch_count++;
                end
                if (got.signature !== exp_res.signature) begin
                    $error("signature_out: expected %h, got %h", exp_res.signature,
                           got.signature);
                    mismatch_count++;
                end
                if (got.live_count !== exp_res.live_count) begin
                    $error("live_count: expected %0d, got %0d", exp_res.live_count,
                           got.live_count);
                    mismatch_count++;
                end
            end
        end
    end

    // Stimulus: reset, directed rows, then phased random traffic.
    initial begin
        logic [2:0] op;
        op_mix_t    mix;
        reset_alloc_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].op, directed_rows[i].target_id,
                      directed_rows[i].comp, directed_rows[i].new_sig,
                      directed_rows[i].typed_exp, directed_rows[i].exp);
        end

        // Mixed traffic, then a fill past an empty pool, then a drain.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n < 250)
                mix = MIX_BALANCED;
            else if (n < 650)
                mix = MIX_FILL;
            else
                mix = MIX_DRAIN;
            op = choose_op(mix);
            send_word(op, pick_target(op == OP_DESTROY ? 80 : 70),
                      COMP_W'($urandom_range(COMPONENT_COUNT - 1)), $urandom(),
                      1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_alloc_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/eida_pkg.sv
hw/rtl/eida_ctrl.sv
hw/rtl/eida_datapath.sv
hw/rtl/entity_id_allocator_with_signatures_top.sv
hw/rtl/eida_checker.sv
tb/sv/testbench.sv
